// ===== rtl/cpot_pkg.sv =====
`timescale 1ns / 1ps
package cpot_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int WAITER_SLOTS  = 8;

	localparam int PAGE_W   = 52;
	localparam int REQ_W    = 22;
	localparam int ENTRY_W  = 4;
	localparam int WSLOT_W  = 3;
	localparam int IN_DW    = 80;
	localparam int IN_UW    = 3;
	localparam int OUT_DW   = 72;
	localparam int OUT_UW   = 3;

	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int SLOT_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
	localparam int USED_W = $clog2(WAITER_SLOTS + 1);

	typedef enum logic [1:0] {
		OP_ACQUIRE  = 2'd0,
		OP_RELEASE  = 2'd1,
		OP_REGISTER = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		OC_GRANTED      = 3'd0,
		OC_WAIT         = 3'd1,
		OC_NOT_REG      = 3'd2,
		OC_WAITERS_FULL = 3'd3,
		OC_RELEASED     = 3'd4,
		OC_NOTHING      = 3'd5,
		OC_REGISTERED   = 3'd6,
		OC_TABLE_FULL   = 3'd7
	} outcome_t;

	typedef enum logic [1:0] {
		PG_PUBLIC = 2'd0,
		PG_SHARED = 2'd1,
		PG_OWNED  = 2'd2
	} page_state_t;

	typedef enum logic [1:0] {
		PROT_BLOCKED = 2'd0,
		PROT_RD_ONLY = 2'd1,
		PROT_RW      = 2'd2
	} prot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REG,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic apply_hit;
		logic load_end;
		logic do_register;
		logic next_idx;
	} cmd_t;

	typedef struct packed {
		logic [1:0] in_op;
		logic       at_end;
		logic       hit;
		logic       out_last;
	} status_t;

	typedef struct packed {
		outcome_t             outcome;
		logic [ENTRY_W-1:0]   entry_index;
		logic [PAGE_W-1:0]    page_out;
		prot_t                protection;
		logic [WSLOT_W-1:0]   wait_slot;
		logic                 wake_valid;
		logic [WSLOT_W-1:0]   wake_slot;
		logic                 last;
	} result_t;

endpackage

// ===== rtl/cpot_ctrl.sv =====
`timescale 1ns / 1ps
module cpot_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	output logic              m_valid,
	input  logic              m_ready,
	input  cpot_pkg::status_t status,
	output cpot_pkg::cmd_t    cmd
);
	import cpot_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		s_ready = 1'b0;
		m_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.capture = 1'b1;
					case (status.in_op)
						OP_ACQUIRE, OP_RELEASE: state_d = ST_SCAN;
						OP_REGISTER:            state_d = ST_REG;
						default:                state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (status.at_end) begin
					cmd.load_end = 1'b1;
					state_d      = ST_OUT;
				end else if (status.hit) begin
					cmd.apply_hit = 1'b1;
					state_d       = ST_OUT;
				end else begin
					cmd.next_idx = 1'b1;
				end
			end
			ST_REG: begin
				cmd.do_register = 1'b1;
				state_d         = ST_OUT;
			end
			ST_OUT: begin
				m_valid = 1'b1;
				if (m_ready) begin
					if (status.out_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next_idx = 1'b1;
						state_d      = ST_SCAN;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/cpot_datapath.sv =====
`timescale 1ns / 1ps
module cpot_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [cpot_pkg::IN_DW-1:0]     in_data,
	input  logic [cpot_pkg::IN_UW-1:0]     in_user,
	input  cpot_pkg::cmd_t                 cmd,
	output cpot_pkg::status_t              status,
	output logic [cpot_pkg::OUT_DW-1:0]    out_data,
	output logic [cpot_pkg::OUT_UW-1:0]    out_user,
	output logic                           out_last
);
	import cpot_pkg::*;

	logic [PAGE_W-1:0]       entry_page [TABLE_ENTRIES];
	page_state_t             entry_state_q [TABLE_ENTRIES];
	logic [REQ_W-1:0]        entry_owner_q [TABLE_ENTRIES];
	logic [USED_W-1:0]       used_q [TABLE_ENTRIES];
	logic [WAITER_SLOTS-1:0] enabled_q [TABLE_ENTRIES];
	logic [CNT_W-1:0]        count_q;

	op_t                     op_q;
	logic [PAGE_W-1:0]       page_q;
	logic [REQ_W-1:0]        req_q;
	logic                    kind_q;
	logic [CNT_W-1:0]        idx_q;
	result_t                 res_q;
	result_t                 res_d;

	logic [IDX_W-1:0]        ix;
	logic                    page_hit;
	logic                    rel_hit;
	logic                    grant;
	logic [TABLE_ENTRIES-1:0] rel_above;
	logic                    wake_found;
	logic [SLOT_W-1:0]       wake_idx;
	logic                    reg_room;

	assign ix       = idx_q[IDX_W-1:0];
	assign page_hit = (entry_page[ix] == page_q);
	assign rel_hit  = (entry_state_q[ix] != PG_PUBLIC) && (entry_owner_q[ix] == req_q);
	assign grant    = (entry_state_q[ix] == PG_PUBLIC) ||
	                  ((entry_state_q[ix] == PG_SHARED) && !kind_q);
	assign reg_room = (count_q < CNT_W'(TABLE_ENTRIES));

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			rel_above[i] = (CNT_W'(i) < count_q) && (CNT_W'(i) > idx_q) &&
			               (entry_state_q[i] != PG_PUBLIC) && (entry_owner_q[i] == req_q);
		end
	end

	always_comb begin
		wake_found = 1'b0;
		wake_idx   = '0;
		for (int j = WAITER_SLOTS - 1; j >= 0; j--) begin
			if (enabled_q[ix][j]) begin
				wake_found = 1'b1;
				wake_idx   = SLOT_W'(j);
			end
		end
	end

	always_comb begin
		status.in_op    = in_user[1:0];
		status.at_end   = (idx_q >= count_q);
		status.hit      = (op_q == OP_ACQUIRE) ? page_hit : rel_hit;
		status.out_last = res_q.last;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op_t'(in_user[1:0]);
			kind_q <= in_user[2];
			page_q <= in_data[PAGE_W-1:0];
			req_q  <= in_data[PAGE_W +: REQ_W];
		end
		if (cmd.do_register && reg_room) begin
			entry_page[count_q[IDX_W-1:0]] <= page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				entry_state_q[i] <= PG_PUBLIC;
				entry_owner_q[i] <= '0;
				used_q[i]        <= '0;
				enabled_q[i]     <= '0;
			end
		end else begin
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.next_idx) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.apply_hit) begin
				if (op_q == OP_ACQUIRE) begin
					if (grant) begin
						entry_owner_q[ix] <= req_q;
						entry_state_q[ix] <= kind_q ? PG_OWNED : PG_SHARED;
					end else if (used_q[ix] < USED_W'(WAITER_SLOTS)) begin
						enabled_q[ix] <= enabled_q[ix] |
						                 (WAITER_SLOTS'(1) << used_q[ix][SLOT_W-1:0]);
						used_q[ix]    <= used_q[ix] + USED_W'(1);
					end
				end else begin
					entry_state_q[ix] <= PG_PUBLIC;
					if (wake_found) begin
						enabled_q[ix] <= enabled_q[ix] & ~(WAITER_SLOTS'(1) << wake_idx);
					end
				end
			end
			if (cmd.do_register && reg_room) begin
				entry_state_q[count_q[IDX_W-1:0]] <= PG_PUBLIC;
				entry_owner_q[count_q[IDX_W-1:0]] <= '0;
				used_q[count_q[IDX_W-1:0]]        <= '0;
				enabled_q[count_q[IDX_W-1:0]]     <= '0;
				count_q                           <= count_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		res_d = '0;
		if (cmd.apply_hit) begin
			res_d.entry_index = ENTRY_W'(ix);
			if (op_q == OP_ACQUIRE) begin
				res_d.page_out = page_q;
				res_d.last     = 1'b1;
				if (grant) begin
					res_d.outcome    = OC_GRANTED;
					res_d.protection = kind_q ? PROT_RW : PROT_RD_ONLY;
				end else if (used_q[ix] < USED_W'(WAITER_SLOTS)) begin
					res_d.outcome   = OC_WAIT;
					res_d.wait_slot = WSLOT_W'(used_q[ix]);
				end else begin
					res_d.outcome = OC_WAITERS_FULL;
				end
			end else begin
				res_d.outcome    = OC_RELEASED;
				res_d.page_out   = entry_page[ix];
				res_d.wake_valid = wake_found;
				res_d.wake_slot  = wake_found ? WSLOT_W'(wake_idx) : '0;
				res_d.last       = ~|rel_above;
			end
		end else if (cmd.load_end) begin
			res_d.last = 1'b1;
			if (op_q == OP_ACQUIRE) begin
				res_d.outcome  = OC_NOT_REG;
				res_d.page_out = page_q;
			end else begin
				res_d.outcome = OC_NOTHING;
			end
		end else if (cmd.do_register) begin
			res_d.last     = 1'b1;
			res_d.page_out = page_q;
			if (reg_room) begin
				res_d.outcome     = OC_REGISTERED;
				res_d.entry_index = ENTRY_W'(count_q);
			end else begin
				res_d.outcome = OC_TABLE_FULL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply_hit || cmd.load_end || cmd.do_register) begin
			res_q <= res_d;
		end
	end

	assign out_user = res_q.outcome;
	assign out_last = res_q.last;
	assign out_data = OUT_DW'({res_q.wake_slot, res_q.wake_valid, res_q.wait_slot,
	                           res_q.protection, res_q.page_out, res_q.entry_index});

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count exceeds the table size");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply_hit |-> !status.at_end)
		else $error("entry update issued past the last registered entry");

	a_end_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_end |-> status.at_end)
		else $error("end-of-scan result issued before the scan finished");

	a_register_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_register && reg_room) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("registration did not add an entry");

endmodule

// ===== rtl/crew_page_ownership_table.sv =====
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)                    tuser (low bit up)         tlast
// s_axis    in   page_number[51:0] requester[73:52]    operation[1:0] access_kind[2]  -
// m_axis    out  entry_index[3:0] page_out[55:4]       outcome[2:0]               last
//                protection[57:56] wait_slot[60:58]
//                wake_valid[61] wake_slot[64:62]
//
// One item is in work at a time; s_axis_tready is high only while the block is idle.
// Acquire and release walk the entry table one entry per cycle, apart from the pauses
// of a release for its result beats; an acquire stops at its first page match, and
// registration gives a single result beat.
// A release stops its walk while a result beat is held by a low m_axis_tready.
// Reset clears the entry count and entry state but not pages; no clearing pass is needed.
module crew_page_ownership_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [cpot_pkg::IN_DW-1:0]    s_axis_tdata,  // page_number, requester
	input  logic [cpot_pkg::IN_UW-1:0]    s_axis_tuser,  // operation, access_kind
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [cpot_pkg::OUT_DW-1:0]   m_axis_tdata,  // entry_index, page_out, protection,
	                                                     // wait_slot, wake_valid, wake_slot
	output logic [cpot_pkg::OUT_UW-1:0]   m_axis_tuser,  // outcome
	output logic                          m_axis_tlast
);
	import cpot_pkg::*;

	cmd_t    cmd;
	status_t status;

	cpot_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	cpot_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.cmd      (cmd),
		.status   (status),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser),
		.out_last (m_axis_tlast)
	);

endmodule
